// ----- sv/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define BPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CODE_W   = 10;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned KPA_W    = 17;
  localparam int unsigned CFG_IDX_W = 3;

  // pressure in 1/16 kPa: (1040 * count + 818400) / 1023
  localparam int unsigned SCALE_W  = 28;
  localparam int unsigned ABS_W    = 26;
  localparam int unsigned DIV_SHIFT = 35;
  localparam int unsigned PROD_W   = 52;
  localparam int unsigned QUO_W    = 17;
  localparam logic [ABS_W-1:0] DIV_RECIP = 26'd33587232;
  localparam logic signed [SCALE_W-1:0] KPA_OFFSET = 28'sd818400;
  localparam logic [ABS_W:0] KPA_DIVISOR = 27'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A0  = 3'd0,
    REG_B1  = 3'd1,
    REG_B2  = 3'd2,
    REG_C12 = 3'd3,
    REG_C11 = 3'd4,
    REG_C22 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0] a0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] c12;
    logic [COEF_W-1:0] c11;
    logic [COEF_W-1:0] c22;
  } coef_set_t;

  function automatic logic signed [ACC_W-1:0] sext_coef(input logic [COEF_W-1:0] v);
    sext_coef = {{(ACC_W-COEF_W){v[COEF_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- sv/bpc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
  logic                           valid;
  logic                           ready;
  logic [bpc_pkg::WORD_W-1:0]     pressure_word;
  logic [bpc_pkg::WORD_W-1:0]     temperature_word;

  modport source (output valid, output pressure_word, output temperature_word, input ready);
  modport sink (input valid, input pressure_word, input temperature_word, output ready);
endinterface

`default_nettype wire

// ----- sv/bpc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bpc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bpc_pkg::CNT_W-1:0]  compensated_count;
  logic signed [bpc_pkg::KPA_W-1:0]  pressure_sixteenth_kpa;

  modport source (output valid, output compensated_count, output pressure_sixteenth_kpa,
                  input ready);
  modport sink (input valid, input compensated_count, input pressure_sixteenth_kpa,
                output ready);
endinterface

`default_nettype wire

// ----- sv/bpc_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bpc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]    index;
  logic [bpc_pkg::COEF_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/barometer_pressure_compensation.sv -----
// channel   dir  payload                                          handshake
// in_if     in   pressure_word, temperature_word                  valid/ready
// out_if    out  compensated_count, pressure_sixteenth_kpa        valid/ready
// cfg_if    in   index (coefficient 0..5), data                   valid/ready
//
// one transfer per cycle sustained while out_if is ready
// four polynomial stages (multiplies in the first and third) and three scaling stages
// each stage holds under stall and takes new data once its successor frees
// rst_n synchronous: clears valids and coefficients, cfg always ready
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module barometer_pressure_compensation (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpc_in_if.sink     in_if,
  bpc_out_if.source  out_if,
  bpc_cfg_if.sink    cfg_if
);

  bpc_pkg::coef_set_t coef;

  logic                             mid_valid;
  logic                             mid_ready;
  logic signed [bpc_pkg::CNT_W-1:0] mid_count;

  bpc_coef_regs u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .coef      (coef)
  );

  bpc_poly u_poly (
    .clk              (clk),
    .rst_n            (rst_n),
    .coef             (coef),
    .in_valid         (in_if.valid),
    .in_ready         (in_if.ready),
    .pressure_word    (in_if.pressure_word),
    .temperature_word (in_if.temperature_word),
    .out_valid        (mid_valid),
    .out_ready        (mid_ready),
    .out_count        (mid_count)
  );

  bpc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_count  (mid_count),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_count (out_if.compensated_count),
    .out_kpa   (out_if.pressure_sixteenth_kpa)
  );

  `BPC_ASSERT_IMP(a_ready_through, clk, rst_n, out_if.ready, in_if.ready, "pipeline blocked with sink ready")
  `BPC_ASSERT_IMP(a_stall_full, clk, rst_n, !in_if.ready, out_if.valid && !out_if.ready, "input stalled without full pipeline")
  `BPC_ASSERT_IMP(a_zero_count, clk, rst_n, out_if.valid && out_if.compensated_count == 16'sd0, out_if.pressure_sixteenth_kpa == 17'sd800, "zero count not at 50 kPa")

endmodule

`default_nettype wire

// ----- sv/bpc_coef_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpc_coef_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bpc_pkg::COEF_W-1:0]      cfg_data,
  output      bpc_pkg::coef_set_t              coef
);

  bpc_pkg::coef_set_t coef_r, coef_nxt;

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bpc_pkg::REG_A0:  coef_nxt.a0  = cfg_data;
        bpc_pkg::REG_B1:  coef_nxt.b1  = cfg_data;
        bpc_pkg::REG_B2:  coef_nxt.b2  = cfg_data;
        bpc_pkg::REG_C12: coef_nxt.c12 = cfg_data;
        bpc_pkg::REG_C11: coef_nxt.c11 = cfg_data;
        bpc_pkg::REG_C22: coef_nxt.c22 = cfg_data;
        default:          coef_nxt     = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bpc_poly.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpc_poly (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire bpc_pkg::coef_set_t                 coef,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [bpc_pkg::WORD_W-1:0]         pressure_word,
  input  wire logic [bpc_pkg::WORD_W-1:0]         temperature_word,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic signed [bpc_pkg::CNT_W-1:0]   out_count
);

  localparam int unsigned AW = bpc_pkg::ACC_W;
  localparam int unsigned CW = bpc_pkg::CODE_W;
  localparam int unsigned WW = bpc_pkg::WORD_W;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  logic [CW-1:0]        p1_r, t1_r, p2_r, t2_r;
  logic signed [AW-1:0] c11p1_r, c12t1_r, c22t1_r;
  logic signed [AW-1:0] a1_2_r, a2_2_r;
  logic signed [AW-1:0] a1p3_r, a2t3_r;
  logic signed [bpc_pkg::CNT_W-1:0] cnt4_r;

  logic [CW-1:0]        p_in, t_in;
  logic signed [AW-1:0] p_in_x, t_in_x, p2_x, t2_x;
  logic signed [AW-1:0] sum_a11, a11, sum_a1, a1, sum_a2, a2;
  logic signed [AW-1:0] sum_y1, y1, acc, acc_adj, pc;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v4_r;
  assign out_count = cnt4_r;

  // stage 1 operands
  assign p_in   = pressure_word[WW-1 -: CW];
  assign t_in   = temperature_word[WW-1 -: CW];
  assign p_in_x = {{(AW-CW){1'b0}}, p_in};
  assign t_in_x = {{(AW-CW){1'b0}}, t_in};

  // stage 2: first-order terms
  always_comb begin
    sum_a11 = (bpc_pkg::sext_coef(coef.b1) <<< 14) + c11p1_r;
    a11     = sum_a11 >>> 14;
    sum_a1  = (a11 <<< 11) + c12t1_r;
    a1      = sum_a1 >>> 11;
    sum_a2  = (bpc_pkg::sext_coef(coef.b2) <<< 15) + (c22t1_r >>> 1);
    a2      = sum_a2 >>> 16;
  end

  assign p2_x = {{(AW-CW){1'b0}}, p2_r};
  assign t2_x = {{(AW-CW){1'b0}}, t2_r};

  // stage 4: sum and divide by 8192 toward zero
  always_comb begin
    sum_y1  = (bpc_pkg::sext_coef(coef.a0) <<< 10) + a1p3_r;
    y1      = sum_y1 >>> 10;
    acc     = (y1 <<< 10) + a2t3_r;
    acc_adj = acc + (acc[AW-1] ? 32'sd8191 : 32'sd0);
    pc      = acc_adj >>> 13;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p1_r    <= p_in;
      t1_r    <= t_in;
      c11p1_r <= bpc_pkg::sext_coef(coef.c11) * p_in_x;
      c12t1_r <= bpc_pkg::sext_coef(coef.c12) * t_in_x;
      c22t1_r <= bpc_pkg::sext_coef(coef.c22) * t_in_x;
    end
    if (rdy2 && v1_r) begin
      p2_r   <= p1_r;
      t2_r   <= t1_r;
      a1_2_r <= a1;
      a2_2_r <= a2;
    end
    if (rdy3 && v2_r) begin
      a1p3_r <= a1_2_r * p2_x;
      a2t3_r <= a2_2_r * t2_x;
    end
    if (rdy4 && v3_r) begin
      cnt4_r <= pc[bpc_pkg::CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/bpc_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpc_scale (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic signed [bpc_pkg::CNT_W-1:0]   in_count,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic signed [bpc_pkg::CNT_W-1:0]   out_count,
  output      logic signed [bpc_pkg::KPA_W-1:0]   out_kpa
);

  localparam int unsigned SW = bpc_pkg::SCALE_W;
  localparam int unsigned XW = bpc_pkg::ABS_W;
  localparam int unsigned QW = bpc_pkg::QUO_W;
  localparam int unsigned NW = bpc_pkg::CNT_W;

  logic rdy5, rdy6, rdy7;
  logic v5_r, v6_r, v7_r;

  logic [XW-1:0]        abs5_r, abs6_r;
  logic                 neg5_r, neg6_r;
  logic signed [NW-1:0] cnt5_r, cnt6_r, cnt7_r;
  logic [QW-1:0]        q6_r;
  logic signed [bpc_pkg::KPA_W-1:0] kpa7_r;

  logic signed [SW-1:0] cnt_x, num, num_abs;
  logic [bpc_pkg::PROD_W-1:0] prod;
  logic [XW:0]          q_mul, rem;
  logic [QW-1:0]        q_fix;
  logic signed [bpc_pkg::KPA_W-1:0] kpa;

  assign rdy7      = !v7_r || out_ready;
  assign rdy6      = !v6_r || rdy7;
  assign rdy5      = !v5_r || rdy6;
  assign in_ready  = rdy5;
  assign out_valid = v7_r;
  assign out_count = cnt7_r;
  assign out_kpa   = kpa7_r;

  // numerator 1040 * count + offset, split into sign and magnitude
  always_comb begin
    cnt_x   = {{(SW-NW){in_count[NW-1]}}, in_count};
    num     = (cnt_x <<< 10) + (cnt_x <<< 4) + bpc_pkg::KPA_OFFSET;
    num_abs = num[SW-1] ? -num : num;
  end

  // reciprocal estimate, low by at most one
  assign prod = {{(bpc_pkg::PROD_W-XW){1'b0}}, abs5_r} *
                {{(bpc_pkg::PROD_W-XW){1'b0}}, bpc_pkg::DIV_RECIP};

  // remainder check and sign restore
  always_comb begin
    q_mul = {q6_r, 10'd0} - {{(XW+1-QW){1'b0}}, q6_r};
    rem   = {1'b0, abs6_r} - q_mul;
    q_fix = (rem >= bpc_pkg::KPA_DIVISOR) ? q6_r + 1'b1 : q6_r;
    kpa   = neg6_r ? -$signed(q_fix) : $signed(q_fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy5) v5_r <= in_valid;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && in_valid) begin
      abs5_r <= num_abs[XW-1:0];
      neg5_r <= num[SW-1];
      cnt5_r <= in_count;
    end
    if (rdy6 && v5_r) begin
      q6_r   <= prod[bpc_pkg::DIV_SHIFT +: QW];
      abs6_r <= abs5_r;
      neg6_r <= neg5_r;
      cnt6_r <= cnt5_r;
    end
    if (rdy7 && v6_r) begin
      kpa7_r <= kpa;
      cnt7_r <= cnt6_r;
    end
  end

endmodule

`default_nettype wire
